>>> rtl/core/message_frame_deframer_assert.svh
// Assertion macros shared by the deframer checker.
`ifndef MESSAGE_FRAME_DEFRAMER_ASSERT_SVH
`define MESSAGE_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MFD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

>>> rtl/core/mfd_pkg.sv
// Shared constants and types of the message frame deframer.
package mfd_pkg;

	// Width of the payload byte counter; long sizes are kept modulo 2^SIZE_BITS.
	localparam int SIZE_BITS = 64;

	// Size byte value that announces an eight-byte size field.
	localparam logic [7:0] LONG_MARK = 8'hFF;

	// Number of bytes in the long size field and the width of its index.
	localparam int LONG_BYTES = 8;
	localparam int LONG_IDX_W = $clog2(LONG_BYTES);

	typedef logic [SIZE_BITS-1:0] size_t;
	typedef logic [LONG_IDX_W-1:0] long_idx_t;

	// One result item.
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] frame_flags;
		logic       last_of_frame;
		logic       empty_frame;
	} frame_t;

	// What the parser hands to the output stage for the byte it holds.
	typedef struct packed {
		logic   emit;
		frame_t result;
	} parse_res_t;

endpackage

>>> rtl/core/mfd_ifs.sv
// Stream interfaces for the deframer: the received byte channel and the result channel.
interface mfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface mfd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [7:0] frame_flags;
	logic       last_of_frame;
	logic       empty_frame;

	modport source (output valid, output data_byte, output frame_flags,
		output last_of_frame, output empty_frame, input ready);
	modport sink (input valid, input data_byte, input frame_flags,
		input last_of_frame, input empty_frame, output ready);
endinterface

>>> rtl/core/mfd_parser.sv
// Frame parser: phase state, flags, size counter and per-byte result decode.
module mfd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         byte_s1,
	input  logic               step,
	output mfd_pkg::parse_res_t res
);
	import mfd_pkg::*;

	typedef enum logic [1:0] {
		PH_FLAGS,
		PH_SIZE,
		PH_LONG,
		PH_DATA
	} phase_t;

	localparam long_idx_t IDX_LAST = long_idx_t'(LONG_BYTES - 1);

	phase_t    phase_q, phase_d;
	logic [7:0] flags_q, flags_d;
	size_t     rem_q, rem_d;
	long_idx_t idx_q, idx_d;

	logic [SIZE_BITS+7:0] shift_cat;
	size_t                shifted;
	size_t                rem_dec;

	assign shift_cat = {rem_q, byte_s1};
	assign shifted   = shift_cat[SIZE_BITS-1:0];
	assign rem_dec   = rem_q - size_t'(1);

	always_comb begin
		phase_d = phase_q;
		flags_d = flags_q;
		rem_d   = rem_q;
		idx_d   = idx_q;
		res     = '0;
		res.result.frame_flags = flags_q;
		unique case (phase_q)
			PH_FLAGS: begin
				flags_d = byte_s1;
				phase_d = PH_SIZE;
			end
			PH_SIZE: begin
				if (byte_s1 == LONG_MARK) begin
					rem_d   = '0;
					idx_d   = '0;
					phase_d = PH_LONG;
				end else if (byte_s1 == 8'd0) begin
					rem_d   = '0;
					phase_d = PH_FLAGS;
					res.emit = 1'b1;
					res.result.last_of_frame = 1'b1;
					res.result.empty_frame   = 1'b1;
				end else begin
					rem_d   = size_t'(byte_s1);
					phase_d = PH_DATA;
				end
			end
			PH_LONG: begin
				rem_d = shifted;
				if (idx_q != IDX_LAST) begin
					idx_d = idx_q + long_idx_t'(1);
				end else begin
					idx_d = '0;
					if (shifted == '0) begin
						phase_d = PH_FLAGS;
						res.emit = 1'b1;
						res.result.last_of_frame = 1'b1;
						res.result.empty_frame   = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				rem_d = rem_dec;
				res.emit = 1'b1;
				res.result.data_byte = byte_s1;
				res.result.last_of_frame = (rem_dec == '0);
				if (rem_dec == '0) begin
					phase_d = PH_FLAGS;
				end
			end
			default: begin
				phase_d = PH_FLAGS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAGS;
			flags_q <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			flags_q <= flags_d;
			rem_q   <= rem_d;
			idx_q   <= idx_d;
		end
	end

endmodule

>>> rtl/core/mfd_out_stage.sv
// Result register: holds one finished result until the sink takes it.
module mfd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  mfd_pkg::parse_res_t res,
	output logic                step,
	mfd_frame_if.source         frames
);
	import mfd_pkg::*;

	logic   valid_q;
	frame_t data_q;
	logic   free;
	logic   load;

	assign free = !valid_q || frames.ready;
	assign load = valid_s1 && res.emit && free;
	assign step = valid_s1 && (!res.emit || free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res.result;
		end
	end

	assign frames.valid         = valid_q;
	assign frames.data_byte     = data_q.data_byte;
	assign frames.frame_flags   = data_q.frame_flags;
	assign frames.last_of_frame = data_q.last_of_frame;
	assign frames.empty_frame   = data_q.empty_frame;

endmodule

>>> rtl/core/message_frame_deframer.sv
// An accepted byte is parsed from the input register and its result is held in the result register.
// Throughput: one byte per clock cycle while the result register is free or the byte makes no result,
// set by the combinational parser step and the result register.
// Flags and size bytes produce no result and never stall, except a size that closes an empty frame.
// Reset (arst_n low, asynchronous) returns to waiting for a flags byte and drops held results.
// The input side keeps accepting while a finished result waits, as long as that byte makes none.
module message_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	mfd_byte_if.sink    stream,
	mfd_frame_if.source frames
);
	import mfd_pkg::*;

	// Input register: the received byte that the parser works on this cycle.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// The parser result for byte_s1 and the advance strobe from the output stage.
	parse_res_t res;
	logic       step;

	// A new transaction is taken when the input register is empty or drains this cycle.
	// The drain condition looks through to frames.ready only when the held byte makes a result.
	assign stream.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.in_byte;
		end
	end

	// The parser advances its frame state exactly once for each byte that leaves the input register.
	mfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.step    (step),
		.res     (res)
	);

	// The output stage decides whether the held byte may leave and captures its result.
	mfd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res      (res),
		.step     (step),
		.frames   (frames)
	);

endmodule

>>> rtl/core/mfd_checker.sv
// Port-level checks of the deframer and their attachment to the top level.
`include "message_frame_deframer_assert.svh"

module mfd_checker (
	input logic         clk,
	input logic         arst_n,
	mfd_byte_if.sink    stream,
	mfd_frame_if.source frames
);

	// Result payload as one vector, so that holding it can be checked at once.
	logic [17:0] out_bits;

	assign out_bits = {frames.data_byte, frames.frame_flags,
		frames.last_of_frame, frames.empty_frame};

	`MFD_ASSERT_NEXT(a_out_hold, clk, arst_n, frames.valid && !frames.ready, frames.valid && $stable(out_bits))
	`MFD_ASSERT_IMPLY(a_empty_form, clk, arst_n, frames.valid && frames.empty_frame, frames.last_of_frame && (frames.data_byte == 8'd0))
	`MFD_ASSERT_IMPLY(a_ready_free, clk, arst_n, !frames.valid, stream.ready)
	`MFD_ASSERT_NEXT(a_stall_hold_in, clk, arst_n, !stream.ready, frames.valid || stream.ready)

endmodule

bind message_frame_deframer mfd_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.stream (stream),
	.frames (frames)
);

>>> tb/sv/deframer_sb_pkg.sv
// Scoreboard for the message frame deframer: a frame parser that predicts results, and their check.
`timescale 1ns / 100ps
package deframer_sb_pkg;
	import mfd_pkg::*;

	// Where the parser stands within the current frame.
	typedef enum logic [1:0] {
		WAIT_FLAGS,
		WAIT_SIZE,
		LONG_SIZE,
		PAYLOAD
	} parse_phase_e;

	class frame_scoreboard;
		parse_phase_e phase;
		logic [7:0]   held_flags;
		size_t        bytes_left;
		long_idx_t    size_idx;
		frame_t       expected_frames[$];
		int unsigned  mismatches;

		function new();
			phase      = WAIT_FLAGS;
			held_flags = '0;
			bytes_left = '0;
			size_idx   = '0;
			mismatches = 0;
		endfunction

		function int unsigned pending();
			return expected_frames.size();
		endfunction

		// A frame whose size is zero yields one empty result that closes it.
		function void close_empty_frame();
			frame_t f;
			f.data_byte     = 8'h00;
			f.frame_flags   = held_flags;
			f.last_of_frame = 1'b1;
			f.empty_frame   = 1'b1;
			expected_frames.push_back(f);
			bytes_left = '0;
			phase      = WAIT_FLAGS;
		endfunction

		// Advances the parser by one accepted byte and queues the result it causes.
		function void take_byte(logic [7:0] b);
			frame_t f;
			case (phase)
				WAIT_FLAGS: begin
					held_flags = b;
					phase      = WAIT_SIZE;
				end
				WAIT_SIZE: begin
					if (b == LONG_MARK) begin
						bytes_left = '0;
						size_idx   = '0;
						phase      = LONG_SIZE;
					end else begin
						bytes_left = size_t'(b);
						if (bytes_left == '0)
							close_empty_frame();
						else
							phase = PAYLOAD;
					end
				end
				LONG_SIZE: begin
					// Most significant byte first; all eight bytes fit in the counter.
					bytes_left = (bytes_left << 8) | size_t'(b);
					if (size_idx != long_idx_t'(LONG_BYTES - 1)) begin
						size_idx = size_idx + long_idx_t'(1);
					end else begin
						size_idx = '0;
						if (bytes_left == '0)
							close_empty_frame();
						else
							phase = PAYLOAD;
					end
				end
				default: begin
					bytes_left      = bytes_left - size_t'(1);
					f.data_byte     = b;
					f.frame_flags   = held_flags;
					f.last_of_frame = (bytes_left == '0);
					f.empty_frame   = 1'b0;
					expected_frames.push_back(f);
					if (bytes_left == '0)
						phase = WAIT_FLAGS;
				end
			endcase
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
					$time, field, want, got);
				mismatches++;
			end
		endfunction

		// Checks one accepted result transaction against the oldest expectation.
		function void check_frame(frame_t got);
			frame_t want;
			if (expected_frames.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, actual %p",
					$time, got);
				mismatches++;
				return;
			end
			want = expected_frames.pop_front();
			compare_field("data_byte", want.data_byte, got.data_byte);
			compare_field("frame_flags", want.frame_flags, got.frame_flags);
			compare_field("last_of_frame", 8'(want.last_of_frame), 8'(got.last_of_frame));
			compare_field("empty_frame", 8'(want.empty_frame), 8'(got.empty_frame));
		endfunction
	endclass

endpackage

>>> tb/sv/tb_top.sv
// Top-level testbench of the message frame deframer: stimulus, handshakes and end of run.
`timescale 1ns / 100ps
module tb_top;
	import mfd_pkg::*;
	import deframer_sb_pkg::*;

	// Roughly how many bytes the directed and random parts of the stream hold together.
	localparam int unsigned STREAM_BYTES = 1650;
	// The receiver's one long hold-off starts after this many bytes went in.
	localparam int unsigned HOLD_AT = 600;
	localparam int unsigned HOLD_CYCLES = 300;
	// Cycles without any transaction before the run is declared hung. The longest
	// honest quiet stretch is the hold-off above plus a sender gap.
	localparam int unsigned STALL_LIMIT = 3000;
	// Cycles to wait at the end once nothing is expected.
	localparam int unsigned DRAIN_CYCLES = 8;

	// How the receiver paces its ready in each stretch of cycles.
	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_THIRD,
		SINK_MOSTLY
	} sink_mode_e;

	logic clk;
	logic arst_n;

	mfd_byte_if  stream_ch ();
	mfd_frame_if frame_ch ();

	message_frame_deframer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.frames (frame_ch)
	);

	frame_scoreboard sb = new();

	// The whole byte stream is built before reset is released.
	logic [7:0]  stream_bytes[$];
	int unsigned directed_len;
	int unsigned bytes_taken;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Appends the flags byte and the size, in the short form or the eight-byte form.
	function automatic void add_header(logic [7:0] flags, size_t size, bit long_form);
		stream_bytes.push_back(flags);
		if (long_form) begin
			stream_bytes.push_back(LONG_MARK);
			for (int k = LONG_BYTES - 1; k >= 0; k--)
				stream_bytes.push_back(size[8*k +: 8]);
		end else begin
			stream_bytes.push_back(size[7:0]);
		end
	endfunction

	function automatic void add_payload(int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			stream_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void add_frame(logic [7:0] flags, int unsigned size, bit long_form);
		add_header(flags, size_t'(size), long_form);
		add_payload(size);
	endfunction

	function automatic void build_stream();
		int unsigned pick;
		logic [7:0]  flags;
		// Directed part: empty frame with a short size and the lowest flags, a
		// one-byte frame with all flag bits set, an empty frame given in the long
		// form, and a one-byte frame given in the long form.
		add_frame(8'h00, 0, 1'b0);
		add_frame(8'hFF, 1, 1'b0);
		add_frame(8'h80, 0, 1'b1);
		add_frame(8'h01, 1, 1'b1);
		directed_len = stream_bytes.size();
		// Random part. Any byte sequence is a legal stream, so the mix only steers
		// the frame sizes: mostly short frames, so that many frames start and end,
		// some long-form sizes and now and then short sizes near the largest one.
		while (stream_bytes.size() < STREAM_BYTES) begin
			pick  = $urandom_range(0, 99);
			flags = 8'($urandom_range(0, 255));
			if (pick < 65)
				add_frame(flags, $urandom_range(0, 8), 1'b0);
			else if (pick < 85)
				add_frame(flags, $urandom_range(9, 40), 1'b0);
			else if (pick < 95)
				add_frame(flags, $urandom_range(0, 40), 1'b1);
			else if (pick < 97)
				add_frame(flags, $urandom_range(256, 300), 1'b1);
			else
				add_frame(flags, $urandom_range(200, 254), 1'b0);
		end
		// The stream ends inside a frame with the top bit of the size set. It never
		// completes, but its first payload bytes exercise the high counter bits.
		add_header(8'h3C, 64'h8000_0000_0000_0000, 1'b1);
		add_payload(24);
	endfunction

	// Offers the stream in bursts of random length with random gaps between them.
	// Once the directed part is in, the sender pauses until every result is back.
	task automatic send_stream();
		int unsigned burst_left;
		int unsigned gap;
		burst_left = 0;
		for (int unsigned i = 0; i < stream_bytes.size(); i++) begin
			if (i == directed_len) begin
				stream_ch.valid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0)
					@(posedge clk);
			end else if (burst_left == 0) begin
				gap = $urandom_range(0, 12);
				if (gap != 0) begin
					stream_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			if (burst_left == 0)
				burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
			stream_ch.valid   <= 1'b1;
			stream_ch.in_byte <= stream_bytes[i];
			@(posedge clk);
			while (!stream_ch.ready)
				@(posedge clk);
			sb.take_byte(stream_bytes[i]);
			bytes_taken++;
			burst_left--;
		end
		stream_ch.valid <= 1'b0;
	endtask

	// Receiver: its ready follows a mode drawn at random from the four sink modes. Once, after
	// enough bytes went in, it holds off for a long stretch while the sender keeps
	// offering, so the block fills up and has to stall its input.
	initial begin : result_sink
		int unsigned tick;
		sink_mode_e  mode;
		bit          hold_done;
		tick      = 0;
		hold_done = 1'b0;
		mode      = SINK_OPEN;
		frame_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && bytes_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				frame_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (tick % 64 == 0)
				mode = sink_mode_e'($urandom_range(0, 3));
			case (mode)
				SINK_OPEN:   frame_ch.ready <= 1'b1;
				SINK_COIN:   frame_ch.ready <= 1'($urandom_range(0, 1));
				SINK_THIRD:  frame_ch.ready <= (tick % 3 == 0);
				default:     frame_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
			tick++;
		end
	end

	// Every result transaction is checked at the edge where it is taken. Both sides
	// are sampled before this edge's updates land, so the values are the ones that
	// were set up for the handshake.
	always @(posedge clk) begin
		if (arst_n && frame_ch.valid && frame_ch.ready)
			sb.check_frame({frame_ch.data_byte, frame_ch.frame_flags,
				frame_ch.last_of_frame, frame_ch.empty_frame});
	end

	// Ends a hung run: counts cycles in which neither channel moves a transaction.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (stream_ch.valid && stream_ch.ready)
					|| (frame_ch.valid && frame_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : main
		arst_n            = 1'b0;
		stream_ch.valid   = 1'b0;
		stream_ch.in_byte = 8'h00;
		bytes_taken       = 0;
		build_stream();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_stream();
		// Let every expected result arrive, then keep waiting so that a
		// stray extra result would still be caught.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			if (sb.pending() != 0)
				$display("%0t: %0d results expected but never seen",
					$time, sb.pending());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
